// File: rtl/bfes_pkg.sv
// Shared types and constants for the frame element stiffness block.
package bfes_pkg;

  // One element description, all fields binary64 bit patterns
  typedef struct packed {
    logic [63:0] young_modulus;
    logic [63:0] area;
    logic [63:0] inertia;
    logic [63:0] length;
    logic [63:0] cos_dir;
    logic [63:0] sin_dir;
  } item_t;

  // Operations of the shared double unit
  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_MUL,
    FOP_DIV
  } fop_e;

  // Request to the double unit
  typedef struct packed {
    logic        start;
    fop_e        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  // binary64 constants
  localparam logic [63:0] F_ZERO   = 64'h0000_0000_0000_0000;
  localparam logic [63:0] F_ONE    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] F_TWO    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] F_FOUR   = 64'h4010_0000_0000_0000;
  localparam logic [63:0] F_SIX    = 64'h4018_0000_0000_0000;
  localparam logic [63:0] F_TWELVE = 64'h4028_0000_0000_0000;
  localparam logic [63:0] F_QNAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] F_QBIT   = 64'h0008_0000_0000_0000;

  // Flip the sign bit
  function automatic logic [63:0] fneg(input logic [63:0] x);
    return {~x[63], x[62:0]};
  endfunction

endpackage

// File: rtl/bfes_front.sv
// Input side: two-entry queue of element descriptions.
module bfes_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  bfes_pkg::item_t item_i,
  output logic            valid_o,
  output bfes_pkg::item_t item_o,
  input  logic            ready_i
);
  import bfes_pkg::*;

  item_t      mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       wr;
  logic       rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];
  assign wr      = push_i && !full_o;
  assign rd      = ready_i && valid_o;

  // Store the pushed transaction
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= item_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) begin
        wp_q <= ~wp_q;
      end
      if (rd) begin
        rp_q <= ~rp_q;
      end
      case ({wr, rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTH
  a_full_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("queue full with unequal pointers");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd3)) else $error("queue count out of range");
`endif

endmodule

// File: rtl/bfes_fpu.sv
// Multi-cycle binary64 add, multiply and divide with round to nearest even.
module bfes_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfes_pkg::fpu_req_t req_i,
  output logic               done_o,
  output logic [63:0]        res_o
);
  import bfes_pkg::*;

  typedef enum logic [2:0] {
    FS_IDLE, FS_PRE, FS_ADD, FS_MUL, FS_MULF, FS_DIV, FS_DIVF, FS_NORM
  } fstate_e;

  fstate_e            state_q;
  fop_e               op_q;
  logic               sa_q, sb_q, sr_q;
  logic signed [13:0] ea_q, eb_q, e_q;
  logic [52:0]        ma_q, mb_q;
  logic [55:0]        m_q;
  logic               st_q;
  logic [105:0]       acc_q;
  logic [53:0]        pp_q;
  logic [1:0]         psel_q;
  logic [5:0]         cnt_q;
  logic [54:0]        rem_q;
  logic [56:0]        quo_q;
  logic [63:0]        res_q;
  logic               done_q;

  // Special operands
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, spec, sgn;
  logic [63:0] spec_res;

  always_comb begin
    a_nan  = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] != 52'd0);
    b_nan  = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] != 52'd0);
    a_inf  = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] == 52'd0);
    b_inf  = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] == 52'd0);
    a_zero = (req_i.a[62:0] == 63'd0);
    b_zero = (req_i.b[62:0] == 63'd0);
    sgn    = req_i.a[63] ^ req_i.b[63];
    spec     = 1'b1;
    spec_res = F_QNAN;
    if (a_nan) begin
      spec_res = req_i.a | F_QBIT;
    end else if (b_nan) begin
      spec_res = req_i.b | F_QBIT;
    end else begin
      case (req_i.op)
        FOP_ADD: begin
          if (a_inf && b_inf && (req_i.a[63] != req_i.b[63])) spec_res = F_QNAN;
          else if (a_inf) spec_res = req_i.a;
          else if (b_inf) spec_res = req_i.b;
          else if (a_zero && b_zero) spec_res = {req_i.a[63] & req_i.b[63], 63'd0};
          else if (a_zero) spec_res = req_i.b;
          else if (b_zero) spec_res = req_i.a;
          else spec = 1'b0;
        end
        FOP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = F_QNAN;
          else if (a_inf || b_inf) spec_res = {sgn, 11'h7FF, 52'd0};
          else if (a_zero || b_zero) spec_res = {sgn, 63'd0};
          else spec = 1'b0;
        end
        FOP_DIV: begin
          if ((a_zero && b_zero) || (a_inf && b_inf)) spec_res = F_QNAN;
          else if (a_inf || b_zero) spec_res = {sgn, 11'h7FF, 52'd0};
          else if (a_zero || b_inf) spec_res = {sgn, 63'd0};
          else spec = 1'b0;
        end
        default: spec = 1'b0;
      endcase
    end
  end

  // Alignment and add or subtract of prenormalized operands
  logic               a_big, sx, sy;
  logic signed [13:0] ex, ey, dd;
  logic [52:0]        mx, my;
  logic [55:0]        ym, ysh;
  logic               yst;
  logic [56:0]        s57, d57;
  logic [55:0]        add_m;
  logic               add_st;
  logic signed [13:0] add_e;

  always_comb begin
    a_big = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
    sx = a_big ? sa_q : sb_q;
    sy = a_big ? sb_q : sa_q;
    ex = a_big ? ea_q : eb_q;
    ey = a_big ? eb_q : ea_q;
    mx = a_big ? ma_q : mb_q;
    my = a_big ? mb_q : ma_q;
    dd = ex - ey;
    ym = {my, 3'b000};
    if (dd > 14'sd55) begin
      ysh = 56'd0;
      yst = 1'b1;
    end else begin
      ysh = ym >> dd[5:0];
      yst = |(ym & ~({56{1'b1}} << dd[5:0]));
    end
    s57 = {1'b0, mx, 3'b000} + {1'b0, ysh};
    d57 = {mx, 3'b000, 1'b0} - {ysh, yst};
    if (sx == sy) begin
      if (s57[56]) begin
        add_m  = s57[56:1];
        add_st = s57[0] | yst;
        add_e  = ex + 14'sd1;
      end else begin
        add_m  = s57[55:0];
        add_st = yst;
        add_e  = ex;
      end
    end else begin
      add_m  = d57[56:1];
      add_st = d57[0];
      add_e  = ex;
    end
  end

  // Partial product of the 53x53 significand multiply
  logic [26:0]  xa, yb;
  logic [53:0]  pp_w;
  logic [105:0] pp_sh;

  always_comb begin
    xa   = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
    yb   = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
    pp_w = xa * yb;
    case (psel_q)
      2'd1:    pp_sh = {25'd0, pp_q, 27'd0};
      2'd2:    pp_sh = {pp_q[51:0], 54'd0};
      default: pp_sh = {52'd0, pp_q};
    endcase
  end

  // One restoring division step
  logic [55:0] t56;
  logic        ge;

  assign t56 = {1'b0, rem_q} - {3'b000, mb_q};
  assign ge  = ~t56[55];

  // Rounding of the normalized result
  logic [52:0]        f53;
  logic               inc;
  logic [53:0]        s54;
  logic signed [13:0] rexp;
  logic [51:0]        rfrac;
  logic [63:0]        rnd_res;

  always_comb begin
    f53 = m_q[55:3];
    inc = m_q[2] & (m_q[1] | m_q[0] | st_q | f53[0]);
    s54 = {1'b0, f53} + {53'd0, inc};
    if (s54[53]) begin
      rexp  = e_q + 14'sd1;
      rfrac = s54[52:1];
    end else begin
      rexp  = s54[52] ? e_q : 14'sd0;
      rfrac = s54[51:0];
    end
    if (rexp >= 14'sd2047) begin
      rnd_res = {sr_q, 11'h7FF, 52'd0};
    end else begin
      rnd_res = {sr_q, rexp[10:0], rfrac};
    end
  end

  // Sequence one operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      op_q    <= FOP_ADD;
      sa_q    <= 1'b0;
      sb_q    <= 1'b0;
      sr_q    <= 1'b0;
      ea_q    <= '0;
      eb_q    <= '0;
      e_q     <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      m_q     <= '0;
      st_q    <= 1'b0;
      acc_q   <= '0;
      pp_q    <= '0;
      psel_q  <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        FS_IDLE: begin
          if (req_i.start) begin
            if (spec) begin
              res_q  <= spec_res;
              done_q <= 1'b1;
            end else begin
              op_q    <= req_i.op;
              sa_q    <= req_i.a[63];
              sb_q    <= req_i.b[63];
              ma_q    <= {req_i.a[62:52] != 11'd0, req_i.a[51:0]};
              mb_q    <= {req_i.b[62:52] != 11'd0, req_i.b[51:0]};
              ea_q    <= (req_i.a[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, req_i.a[62:52]});
              eb_q    <= (req_i.b[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, req_i.b[62:52]});
              state_q <= FS_PRE;
            end
          end
        end
        // Bring subnormal significands to a leading one
        FS_PRE: begin
          if (!ma_q[52]) begin
            ma_q <= {ma_q[51:0], 1'b0};
            ea_q <= ea_q - 14'sd1;
          end
          if (!mb_q[52]) begin
            mb_q <= {mb_q[51:0], 1'b0};
            eb_q <= eb_q - 14'sd1;
          end
          if (ma_q[52] && mb_q[52]) begin
            cnt_q <= 6'd0;
            case (op_q)
              FOP_MUL: begin
                acc_q   <= '0;
                state_q <= FS_MUL;
              end
              FOP_DIV: begin
                rem_q   <= {2'b00, ma_q};
                quo_q   <= '0;
                state_q <= FS_DIV;
              end
              default: state_q <= FS_ADD;
            endcase
          end
        end
        FS_ADD: begin
          m_q     <= add_m;
          st_q    <= add_st;
          e_q     <= add_e;
          sr_q    <= sx;
          state_q <= FS_NORM;
        end
        // Four partial products, each registered and accumulated in the cycle after
        FS_MUL: begin
          if (cnt_q != 6'd0) begin
            acc_q <= acc_q + pp_sh;
          end
          pp_q   <= pp_w;
          psel_q <= {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0]};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'd4) begin
            state_q <= FS_MULF;
          end
        end
        FS_MULF: begin
          sr_q <= sa_q ^ sb_q;
          if (acc_q[105]) begin
            m_q  <= acc_q[105:50];
            st_q <= |acc_q[49:0];
            e_q  <= ea_q + eb_q - 14'sd1022;
          end else begin
            m_q  <= acc_q[104:49];
            st_q <= |acc_q[48:0];
            e_q  <= ea_q + eb_q - 14'sd1023;
          end
          state_q <= FS_NORM;
        end
        // One quotient bit per cycle
        FS_DIV: begin
          quo_q <= {quo_q[55:0], ge};
          rem_q <= ge ? {t56[53:0], 1'b0} : {rem_q[53:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd56) begin
            state_q <= FS_DIVF;
          end
        end
        FS_DIVF: begin
          sr_q <= sa_q ^ sb_q;
          if (quo_q[56]) begin
            m_q  <= quo_q[56:1];
            st_q <= quo_q[0] | (rem_q != 55'd0);
            e_q  <= ea_q - eb_q + 14'sd1023;
          end else begin
            m_q  <= quo_q[55:0];
            st_q <= (rem_q != 55'd0);
            e_q  <= ea_q - eb_q + 14'sd1022;
          end
          state_q <= FS_NORM;
        end
        // Shift to a leading one or into the subnormal range, then round
        FS_NORM: begin
          if ((m_q == 56'd0) && !st_q) begin
            res_q   <= F_ZERO;
            done_q  <= 1'b1;
            state_q <= FS_IDLE;
          end else if (!m_q[55] && (e_q > 14'sd1)) begin
            m_q <= {m_q[54:0], 1'b0};
            e_q <= e_q - 14'sd1;
          end else if (e_q < -14'sd64) begin
            st_q <= st_q | (m_q != 56'd0);
            m_q  <= 56'd0;
            e_q  <= 14'sd1;
          end else if (e_q < 14'sd1) begin
            st_q <= st_q | m_q[0];
            m_q  <= {1'b0, m_q[55:1]};
            e_q  <= e_q + 14'sd1;
          end else begin
            res_q   <= rnd_res;
            done_q  <= 1'b1;
            state_q <= FS_IDLE;
          end
        end
        default: state_q <= FS_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == FS_IDLE)) else $error("operation started while busy");
`endif

endmodule

// File: rtl/bfes_back.sv
// Back end: sequences the stiffness arithmetic and holds the result register.
module bfes_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            emit_local_i,
  input  logic            valid_i,
  input  bfes_pkg::item_t item_i,
  output logic            ready_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [2:0]      row_o,
  output logic [2:0]      col_o,
  output logic [63:0]     value_o,
  output logic            last_o
);
  import bfes_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_GO, ST_SC_WT, ST_EMIT_L,
    ST_R1_MGO, ST_R1_MWT, ST_R1_AGO, ST_R1_AWT,
    ST_R2_RD, ST_R2_MGO, ST_R2_MWT, ST_R2_AGO, ST_R2_AWT, ST_EMIT_G
  } bstate_e;

  bstate_e     state_q;
  item_t       it_q;
  logic        loc_q;
  logic [3:0]  step_q;
  logic [2:0]  i_q, j_q, m_q;
  logic [63:0] l2_q, l3_q, ea_q, eal_q, ei_q, eil_q, eil2_q, eil3_q;
  logic [63:0] ka_q, kb_q, kp_q, kq_q;
  logic [63:0] acc_q, prod_q;
  logic [63:0] t_mem [36];
  logic [63:0] trd_q;
  logic        out_valid_q;
  logic [2:0]  out_row_q, out_col_q;
  logic [63:0] out_value_q;
  logic        out_last_q;

  fpu_req_t    req;
  logic        fdone;
  logic [63:0] fres;
  logic        out_free;

  // Flat index of a 6x6 entry
  function automatic logic [5:0] idx6(input logic [2:0] r, input logic [2:0] c);
    return ({3'b000, r} << 2) + ({3'b000, r} << 1) + {3'b000, c};
  endfunction

  // Entry of the element-frame matrix
  function automatic logic [63:0] kent(input logic [2:0] r, input logic [2:0] c,
      input logic [63:0] eal, input logic [63:0] a, input logic [63:0] b,
      input logic [63:0] p, input logic [63:0] q);
    logic [63:0] v;
    case ({r, c})
      6'o00, 6'o33: v = eal;
      6'o03, 6'o30: v = fneg(eal);
      6'o11, 6'o44: v = a;
      6'o14, 6'o41: v = fneg(a);
      6'o12, 6'o15, 6'o21, 6'o51: v = b;
      6'o24, 6'o42, 6'o45, 6'o54: v = fneg(b);
      6'o22, 6'o55: v = p;
      6'o25, 6'o52: v = q;
      default: v = F_ZERO;
    endcase
    return v;
  endfunction

  // Entry of the block-diagonal rotation
  function automatic logic [63:0] rent(input logic [2:0] r, input logic [2:0] c,
      input logic [63:0] cs, input logic [63:0] sn);
    logic [63:0] v;
    case ({r, c})
      6'o00, 6'o11, 6'o33, 6'o44: v = cs;
      6'o01, 6'o34: v = sn;
      6'o10, 6'o43: v = fneg(sn);
      6'o22, 6'o55: v = F_ONE;
      default: v = F_ZERO;
    endcase
    return v;
  endfunction

  bfes_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (fdone),
    .res_o  (fres)
  );

  assign out_free = !out_valid_q || pop_i;
  assign ready_o  = (state_q == ST_IDLE);

  // Select the operation for the current step
  always_comb begin
    req = '{start: 1'b0, op: FOP_MUL, a: F_ZERO, b: F_ZERO};
    case (state_q)
      ST_SC_GO: begin
        req.start = 1'b1;
        case (step_q)
          4'd0:  begin req.a = it_q.length;        req.b = it_q.length; end
          4'd1:  begin req.a = l2_q;               req.b = it_q.length; end
          4'd2:  begin req.a = it_q.young_modulus; req.b = it_q.area; end
          4'd3:  begin req.op = FOP_DIV; req.a = ea_q; req.b = it_q.length; end
          4'd4:  begin req.a = it_q.young_modulus; req.b = it_q.inertia; end
          4'd5:  begin req.op = FOP_DIV; req.a = ei_q; req.b = it_q.length; end
          4'd6:  begin req.op = FOP_DIV; req.a = ei_q; req.b = l2_q; end
          4'd7:  begin req.op = FOP_DIV; req.a = ei_q; req.b = l3_q; end
          4'd8:  begin req.a = F_TWELVE; req.b = eil3_q; end
          4'd9:  begin req.a = F_SIX;    req.b = eil2_q; end
          4'd10: begin req.a = F_FOUR;   req.b = eil_q; end
          4'd11: begin req.a = F_TWO;    req.b = eil_q; end
          default: req.start = 1'b0;
        endcase
      end
      ST_R1_MGO: begin
        req.start = 1'b1;
        req.a = rent(m_q, i_q, it_q.cos_dir, it_q.sin_dir);
        req.b = kent(m_q, j_q, eal_q, ka_q, kb_q, kp_q, kq_q);
      end
      ST_R2_MGO: begin
        req.start = 1'b1;
        req.a = trd_q;
        req.b = rent(m_q, j_q, it_q.cos_dir, it_q.sin_dir);
      end
      ST_R1_AGO, ST_R2_AGO: begin
        req.start = 1'b1;
        req.op = FOP_ADD;
        req.a = acc_q;
        req.b = prod_q;
      end
      default: req.start = 1'b0;
    endcase
  end

  // Intermediate product matrix: write one entry, read one entry
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_R1_AWT) && fdone && (m_q == 3'd5)) begin
      t_mem[idx6(i_q, j_q)] <= fres;
    end
    trd_q <= t_mem[idx6(i_q, m_q)];
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      it_q        <= '0;
      loc_q       <= 1'b0;
      step_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      l2_q        <= '0;
      l3_q        <= '0;
      ea_q        <= '0;
      eal_q       <= '0;
      ei_q        <= '0;
      eil_q       <= '0;
      eil2_q      <= '0;
      eil3_q      <= '0;
      ka_q        <= '0;
      kb_q        <= '0;
      kp_q        <= '0;
      kq_q        <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Drop the result once popped
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            it_q    <= item_i;
            loc_q   <= emit_local_i;
            step_q  <= 4'd0;
            state_q <= ST_SC_GO;
          end
        end
        ST_SC_GO: state_q <= ST_SC_WT;
        ST_SC_WT: begin
          if (fdone) begin
            case (step_q)
              4'd0:  l2_q   <= fres;
              4'd1:  l3_q   <= fres;
              4'd2:  ea_q   <= fres;
              4'd3:  eal_q  <= fres;
              4'd4:  ei_q   <= fres;
              4'd5:  eil_q  <= fres;
              4'd6:  eil2_q <= fres;
              4'd7:  eil3_q <= fres;
              4'd8:  ka_q   <= fres;
              4'd9:  kb_q   <= fres;
              4'd10: kp_q   <= fres;
              default: kq_q <= fres;
            endcase
            if (step_q == 4'd11) begin
              i_q     <= 3'd0;
              j_q     <= 3'd0;
              m_q     <= 3'd0;
              state_q <= loc_q ? ST_EMIT_L : ST_R1_MGO;
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= ST_SC_GO;
            end
          end
        end
        // Element-frame entries straight out
        ST_EMIT_L: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= i_q;
            out_col_q   <= j_q;
            out_value_q <= kent(i_q, j_q, eal_q, ka_q, kb_q, kp_q, kq_q);
            out_last_q  <= (i_q == 3'd5) && (j_q == 3'd5);
            if (j_q == 3'd5) begin
              j_q <= 3'd0;
              if (i_q == 3'd5) begin
                i_q     <= 3'd0;
                state_q <= ST_IDLE;
              end else begin
                i_q <= i_q + 3'd1;
              end
            end else begin
              j_q <= j_q + 3'd1;
            end
          end
        end
        ST_R1_MGO: state_q <= ST_R1_MWT;
        ST_R1_MWT: begin
          if (fdone) begin
            if (m_q == 3'd0) begin
              acc_q   <= fres;
              m_q     <= 3'd1;
              state_q <= ST_R1_MGO;
            end else begin
              prod_q  <= fres;
              state_q <= ST_R1_AGO;
            end
          end
        end
        ST_R1_AGO: state_q <= ST_R1_AWT;
        // Accumulate; a finished sum goes to the memory
        ST_R1_AWT: begin
          if (fdone) begin
            acc_q   <= fres;
            state_q <= ST_R1_MGO;
            if (m_q == 3'd5) begin
              m_q <= 3'd0;
              if (j_q == 3'd5) begin
                j_q <= 3'd0;
                if (i_q == 3'd5) begin
                  i_q     <= 3'd0;
                  state_q <= ST_R2_RD;
                end else begin
                  i_q <= i_q + 3'd1;
                end
              end else begin
                j_q <= j_q + 3'd1;
              end
            end else begin
              m_q <= m_q + 3'd1;
            end
          end
        end
        ST_R2_RD:  state_q <= ST_R2_MGO;
        ST_R2_MGO: state_q <= ST_R2_MWT;
        ST_R2_MWT: begin
          if (fdone) begin
            if (m_q == 3'd0) begin
              acc_q   <= fres;
              m_q     <= 3'd1;
              state_q <= ST_R2_RD;
            end else begin
              prod_q  <= fres;
              state_q <= ST_R2_AGO;
            end
          end
        end
        ST_R2_AGO: state_q <= ST_R2_AWT;
        ST_R2_AWT: begin
          if (fdone) begin
            acc_q <= fres;
            if (m_q == 3'd5) begin
              state_q <= ST_EMIT_G;
            end else begin
              m_q     <= m_q + 3'd1;
              state_q <= ST_R2_RD;
            end
          end
        end
        // Hand a global entry to the result register
        ST_EMIT_G: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= i_q;
            out_col_q   <= j_q;
            out_value_q <= acc_q;
            out_last_q  <= (i_q == 3'd5) && (j_q == 3'd5);
            m_q         <= 3'd0;
            state_q     <= ST_R2_RD;
            if (j_q == 3'd5) begin
              j_q <= 3'd0;
              if (i_q == 3'd5) begin
                i_q     <= 3'd0;
                state_q <= ST_IDLE;
              end else begin
                i_q <= i_q + 3'd1;
              end
            end else begin
              j_q <= j_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty_o = !out_valid_q;
  assign row_o   = out_row_q;
  assign col_o   = out_col_q;
  assign value_o = out_value_q;
  assign last_o  = out_last_q;

`ifndef SYNTH
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> ((out_row_q == 3'd5) && (out_col_q == 3'd5)))
    else $error("last flag away from the final entry");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdone |-> ((state_q == ST_SC_WT) || (state_q == ST_R1_MWT) || (state_q == ST_R1_AWT)
      || (state_q == ST_R2_MWT) || (state_q == ST_R2_AWT)))
    else $error("arithmetic result arrived while not waiting");
`endif

endmodule

// File: rtl/beam2d_frame_element_stiffness.sv
// Top level of the 2D frame element stiffness matrix generator.
// Each pushed element (E, A, Iz, L, cos, sin as binary64) produces 36 matrix entries in
// row-major order, the final one flagged by last_o. All arithmetic runs on one shared
// multi-cycle binary64 unit: an add takes longer when a cancellation needs normalizing
// shifts and a divide when an operand is subnormal, and an operation with a zero,
// infinite or NaN operand is answered straight from the idle state. The twelve scalar
// terms come first; with emit_local set the 36 entries then leave one per cycle while
// the result register is popped, otherwise the rotation issues 432 multiplies and 360
// adds, most of them on a zero term of the rotation or of the sparse local matrix. A
// two-entry input queue takes new elements while one is being worked on, and the result
// register holds an entry until it is popped.
module beam2d_frame_element_stiffness (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [63:0] young_modulus_i,
  input  logic [63:0] area_i,
  input  logic [63:0] inertia_i,
  input  logic [63:0] length_i,
  input  logic [63:0] cos_dir_i,
  input  logic [63:0] sin_dir_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  row_o,
  output logic [2:0]  col_o,
  output logic [63:0] value_o,
  output logic        last_o
);
  import bfes_pkg::*;

  logic  emit_local_q;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_local_q <= 1'b0;
    end else if (cfg_we_i) begin
      emit_local_q <= cfg_wdata_i;
    end
  end

  assign in_item = '{young_modulus: young_modulus_i, area: area_i, inertia: inertia_i,
                     length: length_i, cos_dir: cos_dir_i, sin_dir: sin_dir_i};

  bfes_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (in_item),
    .valid_o (q_valid),
    .item_o  (q_item),
    .ready_i (q_ready)
  );

  bfes_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_local_i (emit_local_q),
    .valid_i      (q_valid),
    .item_i       (q_item),
    .ready_o      (q_ready),
    .empty_o      (empty),
    .pop_i        (pop),
    .row_o        (row_o),
    .col_o        (col_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the frame element stiffness matrix generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfes_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES    = 3000;

  // One matrix entry as seen on the result side
  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [63:0] value;
    logic        last;
  } entry_t;

  // One row of the directed table; k00 is a hand-typed value of entry (0,0)
  typedef struct {
    item_t       elem;
    bit          typed;
    logic [63:0] k00;
  } dir_row_t;

  localparam logic [63:0] D_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] D_NINF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] D_NAN  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] D_MAX  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] D_SUB  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] D_NZ   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] D_HALF = 64'h3FE0_0000_0000_0000;
  localparam logic [63:0] D_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] young_modulus_i = '0;
  logic [63:0] area_i = '0;
  logic [63:0] inertia_i = '0;
  logic [63:0] length_i = '0;
  logic [63:0] cos_dir_i = '0;
  logic [63:0] sin_dir_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  row_o;
  logic [2:0]  col_o;
  logic [63:0] value_o;
  logic        last_o;

  beam2d_frame_element_stiffness i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .young_modulus_i (young_modulus_i),
    .area_i          (area_i),
    .inertia_i       (inertia_i),
    .length_i        (length_i),
    .cos_dir_i       (cos_dir_i),
    .sin_dir_i       (sin_dir_i),
    .empty           (empty),
    .pop             (pop),
    .row_o           (row_o),
    .col_o           (col_o),
    .value_o         (value_o),
    .last_o          (last_o)
  );

  always #2 clk_i = ~clk_i;

  entry_t      stiff_q[$];
  dir_row_t    typed_q[$];
  bit          local_mode = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned n_elems = 0;
  int unsigned n_entries = 0;
  int unsigned n_err = 0;
  int unsigned n_local = 0;
  int unsigned n_global = 0;
  int unsigned idle_cnt = 0;

  function automatic bit is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // Build the stiffness matrix of one element, rotated to global axes unless local
  function automatic void stiffness_matrix(input item_t el, input bit loc,
                                           output logic [63:0] kv[36]);
    real e, ar, iz, len, c, s, l2, l3, eal, ei, eil, eil2, eil3, a, b, p, q, acc;
    real k[6][6];
    real rr[6][6];
    real t[6][6];
    e = $bitstoreal(el.young_modulus);
    ar = $bitstoreal(el.area);
    iz = $bitstoreal(el.inertia);
    len = $bitstoreal(el.length);
    c = $bitstoreal(el.cos_dir);
    s = $bitstoreal(el.sin_dir);
    l2 = len * len;
    l3 = l2 * len;
    eal = (e * ar) / len;
    ei = e * iz;
    eil = ei / len;
    eil2 = ei / l2;
    eil3 = ei / l3;
    a = 12.0 * eil3;
    b = 6.0 * eil2;
    p = 4.0 * eil;
    q = 2.0 * eil;
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++) begin
        k[i][j] = 0.0;
        rr[i][j] = 0.0;
      end
    k[0][0] = eal;  k[0][3] = -eal; k[3][0] = -eal; k[3][3] = eal;
    k[1][1] = a;  k[1][2] = b;  k[1][4] = -a; k[1][5] = b;
    k[2][1] = b;  k[2][2] = p;  k[2][4] = -b; k[2][5] = q;
    k[4][1] = -a; k[4][2] = -b; k[4][4] = a;  k[4][5] = -b;
    k[5][1] = b;  k[5][2] = q;  k[5][4] = -b; k[5][5] = p;
    if (!loc) begin
      for (int base = 0; base < 6; base += 3) begin
        rr[base][base] = c;
        rr[base][base+1] = s;
        rr[base+1][base] = -s;
        rr[base+1][base+1] = c;
        rr[base+2][base+2] = 1.0;
      end
      // T = RR^T k, products summed in increasing order
      for (int i = 0; i < 6; i++)
        for (int j = 0; j < 6; j++) begin
          acc = rr[0][i] * k[0][j];
          for (int m = 1; m < 6; m++) acc = acc + rr[m][i] * k[m][j];
          t[i][j] = acc;
        end
      for (int i = 0; i < 6; i++)
        for (int j = 0; j < 6; j++) begin
          acc = t[i][0] * rr[0][j];
          for (int m = 1; m < 6; m++) acc = acc + t[i][m] * rr[m][j];
          k[i][j] = acc;
        end
    end
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++) kv[i*6+j] = $realtobits(k[i][j]);
  endfunction

  // Predict on input transactions, check result transactions, watch for a hang
  always @(posedge clk_i) begin
    logic [63:0] kv[36];
    dir_row_t    dr;
    entry_t      got;
    entry_t      exp_e;
    if (rst_ni) begin
      if (push && !full) begin
        stiffness_matrix('{young_modulus_i, area_i, inertia_i, length_i, cos_dir_i,
                           sin_dir_i}, local_mode, kv);
        dr = typed_q.pop_front();
        if (dr.typed) kv[0] = dr.k00;
        for (int n = 0; n < 36; n++)
          stiff_q.push_back('{row: 3'(n / 6), col: 3'(n % 6), value: kv[n],
                              last: (n == 35)});
        n_elems++;
        if (local_mode) n_local++; else n_global++;
      end
      if (pop && !empty) begin
        got = '{row: row_o, col: col_o, value: value_o, last: last_o};
        n_entries++;
        if (stiff_q.size() == 0) begin
          $error("entry (%0d,%0d) popped with nothing expected", row_o, col_o);
          n_err++;
        end else begin
          exp_e = stiff_q.pop_front();
          if (got.row !== exp_e.row) begin
            $error("row: expected %0d, got %0d", exp_e.row, got.row);
            n_err++;
          end
          if (got.col !== exp_e.col) begin
            $error("col: expected %0d, got %0d", exp_e.col, got.col);
            n_err++;
          end
          // any quiet NaN stands for any other: payloads are not defined across platforms
          if (!(is_nan(exp_e.value) && is_nan(got.value)) && got.value !== exp_e.value) begin
            $error("value (%0d,%0d): expected %h, got %h", exp_e.row, exp_e.col,
                   exp_e.value, got.value);
            n_err++;
          end
          if (got.last !== exp_e.last) begin
            $error("last: expected %0b, got %0b", exp_e.last, got.last);
            n_err++;
          end
        end
      end
      if (cfg_we_i) local_mode = cfg_wdata_i;
      if ((push && !full) || (pop && !empty)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** beam2d_frame_element_stiffness: FAILED **");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Offer one element and hold it until accepted
  task automatic send_elem(input item_t el, input bit typed, input logic [63:0] k00);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    typed_q.push_back('{elem: el, typed: typed, k00: k00});
    push            <= 1'b1;
    young_modulus_i <= el.young_modulus;
    area_i          <= el.area;
    inertia_i       <= el.inertia;
    length_i        <= el.length;
    cos_dir_i       <= el.cos_dir;
    sin_dir_i       <= el.sin_dir;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Lower push and wait until every expected entry has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (stiff_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] special_val();
    case ($urandom_range(0, 8))
      0: return F_ZERO;
      1: return D_NZ;
      2: return D_INF;
      3: return D_NINF;
      4: return D_NAN;
      5: return D_MAX;
      6: return D_SUB;
      7: return D_ONES;
      default: return F_ONE;
    endcase
  endfunction

  // Mostly physical elements, some raw bit patterns and IEEE corner values
  function automatic item_t rand_elem();
    item_t el;
    real   ang;
    int    kind;
    kind = $urandom_range(0, 9);
    ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
    el.young_modulus = $realtobits(1.0e3 + $urandom_range(0, 1000000) * 2.0e5);
    el.area          = $realtobits(1.0e-4 + $urandom_range(0, 100000) * 1.0e-6);
    el.inertia       = $realtobits(1.0e-8 + $urandom_range(0, 100000) * 1.0e-9);
    el.length        = $realtobits(0.05 + $urandom_range(0, 100000) * 1.0e-3);
    el.cos_dir       = $realtobits($cos(ang));
    el.sin_dir       = $realtobits($sin(ang));
    if ($urandom_range(0, 1) == 0) begin
      el.young_modulus[63] = 1'($urandom_range(0, 1));
      el.length[63] = 1'($urandom_range(0, 1));
    end
    if (kind == 0) begin
      el = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind == 1) begin
      case ($urandom_range(0, 5))
        0: el.young_modulus = special_val();
        1: el.area = special_val();
        2: el.inertia = special_val();
        3: el.length = special_val();
        4: el.cos_dir = special_val();
        default: el.sin_dir = special_val();
      endcase
    end
    return el;
  endfunction

  task automatic random_phase(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_elem(rand_elem(), 1'b0, F_ZERO);
  endtask

  // Directed table: global rows at reset value, then local rows
  dir_row_t dir_tab[$];
  logic [63:0] c45;

  initial begin
    c45 = $realtobits(0.70710678118654752);
    // global: unit element along x, zero modulus, zero and negative-zero length,
    // infinite and NaN modulus, vertical and diagonal axes, subnormal and max terms
    dir_tab.push_back('{'{F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO}, 1'b1, F_ONE});
    dir_tab.push_back('{'{F_ZERO, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO}, 1'b1, F_ZERO});
    dir_tab.push_back('{'{F_ONE, F_ONE, F_ONE, F_ZERO, F_ONE, F_ZERO}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{F_ONE, F_ONE, F_ONE, D_NZ, F_ONE, F_ZERO}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{D_INF, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{D_NAN, F_ONE, F_ONE, F_ONE, F_ZERO, F_ONE}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{F_TWELVE, F_SIX, F_FOUR, F_TWO, c45, c45}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{D_SUB, D_MAX, D_SUB, D_SUB, D_MAX, D_NINF}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{D_ONES, D_ONES, D_ONES, D_ONES, D_ONES, D_ONES}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO}, 1'b0, F_ZERO});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) send_elem(dir_tab[n].elem, dir_tab[n].typed, dir_tab[n].k00);

    // local: EA/L reads directly off entry (0,0)
    set_mode(1'b1);
    dir_tab.delete();
    dir_tab.push_back('{'{F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ZERO}, 1'b1, F_ONE});
    dir_tab.push_back('{'{F_TWO, 64'h4008_0000_0000_0000, F_ONE, F_ONE, F_ZERO, F_ZERO},
                        1'b1, F_SIX});
    dir_tab.push_back('{'{F_ONE, F_ONE, F_ONE, F_TWO, F_ONE, F_ZERO}, 1'b1, D_HALF});
    dir_tab.push_back('{'{F_ONE, F_ONE, F_ONE, F_ZERO, F_ONE, F_ZERO}, 1'b1, D_INF});
    dir_tab.push_back('{'{D_MAX, D_MAX, D_MAX, D_SUB, D_NAN, D_NAN}, 1'b0, F_ZERO});
    dir_tab.push_back('{'{D_NINF, F_ZERO, D_NINF, D_NZ, F_ZERO, F_ZERO}, 1'b0, F_ZERO});
    foreach (dir_tab[n]) send_elem(dir_tab[n].elem, dir_tab[n].typed, dir_tab[n].k00);

    // local random, with a long hold-off on the result side and one full drain
    hold_req = 1'b1;
    random_phase(80);
    drain();
    random_phase(70);

    set_mode(1'b0);
    random_phase(60);

    set_mode(1'b1);
    random_phase(80);

    set_mode(1'b0);
    random_phase(55);

    // last stretch runs at full rate in local mode
    set_mode(1'b1);
    quiet = 1'b1;
    random_phase(70);

    push <= 1'b0;
    @(posedge clk_i);
    while (stiff_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d elements (%0d local, %0d rotated), %0d entries checked",
             n_elems, n_local, n_global, n_entries);
    $display("both register settings, IEEE corner values, stalls and a full input queue");
    if (n_err == 0 && stiff_q.size() == 0) begin
      $display("** beam2d_frame_element_stiffness: PASSED **");
    end else begin
      if (stiff_q.size() != 0) $error("%0d expected entries never arrived", stiff_q.size());
      $display("** beam2d_frame_element_stiffness: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bfes_pkg.sv
rtl/bfes_front.sv
rtl/bfes_fpu.sv
rtl/bfes_back.sv
rtl/beam2d_frame_element_stiffness.sv
dv/tb_top.sv
